>>> design/vdi_pkg.sv
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared types and constants for the vertex deduplication indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

	localparam int unsigned MaxVerticesDefault = 1024;
	localparam int unsigned SlotCountDefault   = 2048;
	localparam int unsigned GenWidth           = 5;
	localparam int unsigned OutIndexWidth      = 10;
	localparam int unsigned WordCount          = 8;
	localparam logic [63:0] HashGolden         = 64'h0000_0000_9e37_79b9;

	typedef struct packed {
		logic        new_mesh;
		logic [31:0] normal_x;
		logic [31:0] normal_y;
		logic [31:0] normal_z;
		logic [31:0] position_x;
		logic [31:0] position_y;
		logic [31:0] position_z;
		logic [31:0] texcoord_u;
		logic [31:0] texcoord_v;
	} in_item_t;

	typedef struct packed {
		logic [OutIndexWidth-1:0] vertex_index;
		logic                     is_new;
		logic                     table_full;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture input vertex, start hashing
		logic hash_step;   // one combine round
		logic set_slot;    // slot pointer := hash mod slot count
		logic rd_slot;     // issue slot read at pointer
		logic rd_vert;     // issue vertex word reads for the slot's index
		logic adv_slot;    // pointer := pointer + 1 (wrapping)
		logic insert;      // write slot and vertex words, bump free index
		logic clr_step;    // clear one slot in the sweep
		logic clr_start;   // reset the sweep pointer
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hash_done;
		logic slot_live;
		logic idx_ok;      // stored index below the vertex limit
		logic vert_match;
		logic index_full;
		logic clr_done;
		logic gen_wrap;    // new mesh will wrap the generation
	} dp_sts_t;

endpackage

>>> design/vdi_datapath.sv
// ----------------------------------------------------------------------------
// vdi_datapath
// Hash unit, slot memory, vertex memory and index bookkeeping.
// ----------------------------------------------------------------------------
module vdi_datapath #(
	parameter int unsigned MAX_VERTICES = vdi_pkg::MaxVerticesDefault,
	parameter int unsigned SLOT_COUNT   = vdi_pkg::SlotCountDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vdi_pkg::in_item_t in_item,
	input  vdi_pkg::dp_cmd_t  cmd,
	output vdi_pkg::dp_sts_t  sts,
	output logic [vdi_pkg::OutIndexWidth-1:0] hit_index,
	output logic [vdi_pkg::OutIndexWidth-1:0] new_index
);
	localparam int unsigned VIdxW = $clog2(MAX_VERTICES);
	localparam int unsigned CntW  = VIdxW + 1;
	localparam int unsigned SlotW = $clog2(SLOT_COUNT);
	localparam int unsigned GenW  = vdi_pkg::GenWidth;
	localparam int unsigned EntW  = 1 + GenW + CntW;
	localparam int unsigned OutW  = vdi_pkg::OutIndexWidth;

	logic [31:0]        words_q [vdi_pkg::WordCount];
	logic [63:0]        seed_q;
	logic [2:0]         hcnt_q;
	logic               hdone_q;
	logic [SlotW-1:0]   slot_q;
	logic [SlotW-1:0]   clr_q;
	logic               clr_done_q;
	logic [GenW-1:0]    gen_q;
	logic [CntW-1:0]    free_q;

	logic [EntW-1:0]    slot_mem [SLOT_COUNT];
	logic [EntW-1:0]    slot_rd_q;
	logic [255:0]       vert_mem [MAX_VERTICES];
	logic [255:0]       vert_rd_q;

	logic [255:0]       packed_vtx;
	logic               rd_valid;
	logic [GenW-1:0]    rd_gen;
	logic [CntW-1:0]    rd_idx;
	logic [63:0]        word_ext;

	assign packed_vtx = {words_q[0], words_q[1], words_q[2], words_q[3],
	                     words_q[4], words_q[5], words_q[6], words_q[7]};
	assign rd_valid = slot_rd_q[EntW-1];
	assign rd_gen   = slot_rd_q[EntW-2 -: GenW];
	assign rd_idx   = slot_rd_q[CntW-1:0];
	assign word_ext = {32'd0, words_q[hcnt_q]};

	// control and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q     <= '0;
			hdone_q    <= 1'b0;
			gen_q      <= '0;
			free_q     <= '0;
			clr_q      <= '0;
			clr_done_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				hcnt_q  <= '0;
				hdone_q <= 1'b0;
				if (in_item.new_mesh) begin
					gen_q  <= gen_q + 1'b1;
					free_q <= '0;
				end
			end else if (cmd.hash_step) begin
				hcnt_q <= hcnt_q + 1'b1;
				if (hcnt_q == 3'd7)
					hdone_q <= 1'b1;
			end
			if (cmd.insert)
				free_q <= free_q + 1'b1;
			if (cmd.clr_start) begin
				clr_q      <= '0;
				clr_done_q <= 1'b0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == SlotW'(SLOT_COUNT - 1))
					clr_done_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			words_q[0] <= in_item.normal_x;
			words_q[1] <= in_item.normal_y;
			words_q[2] <= in_item.normal_z;
			words_q[3] <= in_item.position_x;
			words_q[4] <= in_item.position_y;
			words_q[5] <= in_item.position_z;
			words_q[6] <= in_item.texcoord_u;
			words_q[7] <= in_item.texcoord_v;
			seed_q     <= '0;
		end else if (cmd.hash_step) begin
			seed_q <= seed_q ^ (word_ext + vdi_pkg::HashGolden + (seed_q << 6)
			                    + (seed_q >> 2));
		end
		if (cmd.set_slot)
			slot_q <= seed_q[SlotW-1:0];
		else if (cmd.adv_slot)
			slot_q <= (slot_q == SlotW'(SLOT_COUNT - 1)) ? '0 : slot_q + 1'b1;
	end

	// slot memory: one write port, one registered read
	always_ff @(posedge clk) begin
		if (cmd.clr_step)
			slot_mem[clr_q] <= '0;
		else if (cmd.insert)
			slot_mem[slot_q] <= {1'b1, gen_q, free_q};
		if (cmd.rd_slot)
			slot_rd_q <= slot_mem[slot_q];
	end

	// vertex memory
	always_ff @(posedge clk) begin
		if (cmd.insert)
			vert_mem[free_q[VIdxW-1:0]] <= packed_vtx;
		if (cmd.rd_vert)
			vert_rd_q <= vert_mem[rd_idx[VIdxW-1:0]];
	end

	assign sts.hash_done  = hdone_q;
	assign sts.slot_live  = rd_valid && (rd_gen == gen_q);
	assign sts.idx_ok     = rd_idx < CntW'(MAX_VERTICES);
	assign sts.vert_match = vert_rd_q == packed_vtx;
	assign sts.index_full = free_q >= CntW'(MAX_VERTICES);
	assign sts.clr_done   = clr_done_q;
	assign sts.gen_wrap   = gen_q == {GenW{1'b1}};

	assign hit_index = OutW'(rd_idx);
	assign new_index = OutW'(free_q);
endmodule

>>> design/vdi_ctrl.sv
// ----------------------------------------------------------------------------
// vdi_ctrl
// Sequencer: clear sweep, hashing, probe loop and result register.
// ----------------------------------------------------------------------------
module vdi_ctrl #(
	parameter int unsigned SLOT_COUNT = vdi_pkg::SlotCountDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_new_mesh,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output vdi_pkg::out_item_t  out_item,
	output vdi_pkg::dp_cmd_t    cmd,
	input  vdi_pkg::dp_sts_t    sts,
	input  logic [vdi_pkg::OutIndexWidth-1:0] hit_index,
	input  logic [vdi_pkg::OutIndexWidth-1:0] new_index
);
	localparam int unsigned PW = $clog2(SLOT_COUNT) + 1;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_SLOT, ST_CHECK, ST_CMP, ST_DONE
	} state_t;

	state_t                 state_q;
	logic [PW-1:0]          probes_q;
	logic                   wipe_q;
	vdi_pkg::out_item_t     res_q;
	logic                   res_valid_q;

	logic accept;
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !res_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: cmd.clr_step = !sts.clr_done;
			ST_IDLE:  cmd.load = accept;
			ST_HASH:  begin
				cmd.hash_step = !sts.hash_done;
				cmd.set_slot  = sts.hash_done;
			end
			ST_SLOT:  cmd.rd_slot = 1'b1;
			ST_CHECK: begin
				cmd.rd_vert = 1'b1;
				cmd.insert  = !sts.slot_live && !sts.index_full;
			end
			ST_CMP:   cmd.adv_slot = 1'b1;
			ST_DONE:  cmd = '0;
			default:  cmd = '0;
		endcase
		if (state_q == ST_IDLE && accept && in_new_mesh && sts.gen_wrap)
			cmd.clr_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			probes_q    <= '0;
			wipe_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (out_valid && out_ready)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: if (sts.clr_done)
					state_q <= wipe_q ? ST_HASH : ST_IDLE;
				ST_IDLE: if (accept) begin
					probes_q <= '0;
					wipe_q   <= in_new_mesh && sts.gen_wrap;
					state_q  <= (in_new_mesh && sts.gen_wrap) ? ST_CLEAR : ST_HASH;
				end
				ST_HASH: if (sts.hash_done)
					state_q <= ST_SLOT;
				ST_SLOT: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (!sts.slot_live) begin
						res_q       <= sts.index_full
							? vdi_pkg::out_item_t'{'0, 1'b0, 1'b1}
							: vdi_pkg::out_item_t'{new_index, 1'b1, 1'b0};
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else
						state_q <= ST_CMP;
				end
				ST_CMP: begin
					// hold the stored index from the slot read for a hit
					if (sts.idx_ok && sts.vert_match) begin
						res_q       <= '{hit_index, 1'b0, 1'b0};
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (probes_q == PW'(SLOT_COUNT - 1)) begin
						res_q       <= '{'0, 1'b0, 1'b1};
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						probes_q <= probes_q + 1'b1;
						state_q  <= ST_SLOT;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = res_valid_q;
	assign out_item  = res_q;
endmodule

>>> design/vertex_dedup_indexer_core.sv
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_core
// Hash-table vertex deduplication with linear probing.
// ----------------------------------------------------------------------------
// One vertex at a time: after the accept, one combine round per word and then
// slot select, then per probe a slot memory read and a check, plus a vertex
// memory read and 256-bit compare when the slot is live. The result is held
// in a register, and the next vertex is taken in the cycle after its transfer.
// After reset, and on every new mesh that wraps the 5-bit generation, a
// clearing pass sweeps the slot memory one slot a cycle, during which no
// vertex is taken.
module vertex_dedup_indexer_core #(
	parameter int unsigned MAX_VERTICES = vdi_pkg::MaxVerticesDefault,
	parameter int unsigned SLOT_COUNT   = vdi_pkg::SlotCountDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  vdi_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output vdi_pkg::out_item_t out_data
);
	vdi_pkg::dp_cmd_t cmd;
	vdi_pkg::dp_sts_t sts;
	logic [vdi_pkg::OutIndexWidth-1:0] hit_index;
	logic [vdi_pkg::OutIndexWidth-1:0] new_index;

	vdi_datapath #(.MAX_VERTICES(MAX_VERTICES), .SLOT_COUNT(SLOT_COUNT)) u_dp (
		.clk, .arst_n, .in_item(in_data), .cmd, .sts, .hit_index, .new_index
	);

	vdi_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_new_mesh(in_data.new_mesh), .in_ready,
		.out_valid, .out_ready, .out_item(out_data), .cmd, .sts, .hit_index,
		.new_index
	);

	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");
	a_full_not_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.is_new && out_data.table_full))
		else $error("result both new and full");
	a_insert_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !sts.index_full) else $error("insert beyond vertex limit");
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives vertices into the deduplication indexer with random idling on both
// sides and checks every returned index against a slot-table predictor.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned MaxVerts  = 1024;
	localparam int unsigned Slots     = 2048;
	localparam int unsigned CycleLimit = 4_000_000;

	class vertex_index_scoreboard;
		logic [255:0] stored_verts[MaxVerts];
		logic         slot_valid[Slots];
		logic [4:0]   slot_gen[Slots];
		int unsigned  slot_index[Slots];
		logic [4:0]   mesh_gen;
		int unsigned  free_index;
		vdi_pkg::out_item_t pending_results[$];
		int           fail_count;

		function new();
			foreach (slot_valid[i]) begin
				slot_valid[i] = 1'b0;
				slot_gen[i]   = '0;
				slot_index[i] = 0;
			end
			mesh_gen   = '0;
			free_index = 0;
			fail_count = 0;
		endfunction

		function void note_vertex(vdi_pkg::in_item_t it);
			logic [31:0]  words[8];
			logic [63:0]  seed;
			logic [255:0] packed_vert;
			int unsigned  s;
			int unsigned  idx;
			vdi_pkg::out_item_t res;
			if (it.new_mesh) begin
				mesh_gen = mesh_gen + 5'd1;
				if (mesh_gen == 5'd0)
					foreach (slot_valid[i]) slot_valid[i] = 1'b0;
				free_index = 0;
			end
			words = '{it.normal_x, it.normal_y, it.normal_z, it.position_x,
				it.position_y, it.position_z, it.texcoord_u, it.texcoord_v};
			packed_vert = {it.normal_x, it.normal_y, it.normal_z, it.position_x,
				it.position_y, it.position_z, it.texcoord_u, it.texcoord_v};
			seed = '0;
			foreach (words[i])
				seed ^= {32'd0, words[i]} + vdi_pkg::HashGolden + (seed << 6)
					+ (seed >> 2);
			s   = seed % Slots;
			res = '{vertex_index: '0, is_new: 1'b0, table_full: 1'b1};
			for (int n = 0; n < Slots; n++) begin
				if (!(slot_valid[s] && slot_gen[s] == mesh_gen)) begin
					if (free_index >= MaxVerts)
						break;
					stored_verts[free_index] = packed_vert;
					slot_valid[s] = 1'b1;
					slot_gen[s]   = mesh_gen;
					slot_index[s] = free_index;
					res = '{vertex_index: free_index[9:0], is_new: 1'b1, table_full: 1'b0};
					free_index++;
					break;
				end
				idx = slot_index[s];
				if (idx < MaxVerts && stored_verts[idx] == packed_vert) begin
					res = '{vertex_index: idx[9:0], is_new: 1'b0, table_full: 1'b0};
					break;
				end
				s = (s + 1 == Slots) ? 0 : s + 1;
			end
			pending_results = {pending_results, res};
		endfunction

		function void check_index(vdi_pkg::out_item_t got);
			vdi_pkg::out_item_t exp;
			if (pending_results.size() == 0) begin
				$error("unexpected result index=%0d", got.vertex_index);
				fail_count++;
				return;
			end
			exp = pending_results.pop_front();
			if (got.vertex_index !== exp.vertex_index) begin
				$error("vertex_index exp=%0d got=%0d", exp.vertex_index, got.vertex_index);
				fail_count++;
			end
			if (got.is_new !== exp.is_new) begin
				$error("is_new exp=%0b got=%0b", exp.is_new, got.is_new);
				fail_count++;
			end
			if (got.table_full !== exp.table_full) begin
				$error("table_full exp=%0b got=%0b", exp.table_full, got.table_full);
				fail_count++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	vdi_pkg::in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	vdi_pkg::out_item_t out_data;

	vertex_index_scoreboard sb;
	bit        quiet;
	bit        hold_req;
	vdi_pkg::in_item_t  mesh_pool[$];
	int        sent;

	vertex_dedup_indexer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] pick_word();
		case ($urandom % 8)
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fc0_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic vdi_pkg::in_item_t fresh_vertex(bit start_mesh);
		vdi_pkg::in_item_t v;
		v = '{new_mesh: start_mesh, normal_x: pick_word(), normal_y: pick_word(),
			normal_z: pick_word(), position_x: $urandom, position_y: $urandom,
			position_z: $urandom, texcoord_u: pick_word(), texcoord_v: pick_word()};
		return v;
	endfunction

	// hold valid until the transfer, then optionally idle before the next one
	task automatic send_vertex(vdi_pkg::in_item_t v);
		if (!quiet && ($urandom % 6 == 0)) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_vertex(v);
		if (v.new_mesh)
			mesh_pool.delete();
		mesh_pool = {mesh_pool, v};
		sent++;
	endtask

	// mostly repeats of this mesh's vertices, some fresh, some one bit off
	task automatic send_mixed(bit start_mesh);
		vdi_pkg::in_item_t v;
		int       r;
		r = $urandom % 10;
		if (start_mesh || mesh_pool.size() == 0 || r < 4)
			v = fresh_vertex(start_mesh);
		else begin
			v = mesh_pool[$urandom % mesh_pool.size()];
			v.new_mesh = 1'b0;
			if (r == 9)
				v.texcoord_v[$urandom % 32] ^= 1'b1;
		end
		send_vertex(v);
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_index(out_data);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = 400;
				out_ready <= 1'b0;
			end else if (!quiet && ($urandom % 8 == 0)) begin
				stall_left = $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		vdi_pkg::in_item_t v;
		int       mesh_len;
		sb       = new();
		quiet    = 1'b0;
		hold_req = 1'b0;
		sent     = 0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, repeats, signed zero, NaN patterns, mesh restart
		v = '0;
		send_vertex(v);
		v = '{1'b0, '1, '1, '1, '1, '1, '1, '1, '1};
		send_vertex(v);
		v = '0;
		send_vertex(v);
		v.position_x = 32'h8000_0000;
		send_vertex(v);
		v = '{1'b0, 32'h7fc0_0000, '0, '0, 32'h7f80_0001, '0, '0, 32'h7fc0_0000, '0};
		send_vertex(v);
		send_vertex(v);
		v = '{1'b0, '1, '1, '1, '1, '1, '1, '1, '1};
		send_vertex(v);
		v = '0;
		v.new_mesh = 1'b1;
		send_vertex(v);
		v.new_mesh = 1'b0;
		send_vertex(v);
		v = '{1'b1, '1, '1, '1, '1, '1, '1, '1, '1};
		send_vertex(v);
		for (int i = 0; i < 6; i++)
			send_mixed(1'b0);

		// let the output back up so the core stalls its input
		hold_req = 1'b1;
		for (int m = 0; m < 20; m++) begin
			mesh_len = $urandom_range(1, 20);
			for (int i = 0; i < mesh_len; i++)
				send_mixed(i == 0);
		end

		// one mesh that runs out of indices, then seen and unseen vertices
		send_vertex(fresh_vertex(1'b1));
		for (int i = 0; i < MaxVerts + 4; i++)
			send_vertex(fresh_vertex(1'b0));
		for (int i = 0; i < 30; i++)
			send_mixed(1'b0);

		// many short meshes to wrap the generation counter
		while (sent < 1950) begin
			if (sent > 1800)
				quiet = 1'b1;
			mesh_len = $urandom_range(1, 12);
			for (int i = 0; i < mesh_len; i++)
				send_mixed(i == 0);
		end
		in_valid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
design/vdi_pkg.sv
design/vdi_datapath.sv
design/vdi_ctrl.sv
design/vertex_dedup_indexer_core.sv
tb/sv/tb_top.sv
